>>> design/plen_pkg.sv
// plen_pkg: shared types, codes and sizes for the positional list engine
// no dependencies; read by the interfaces, the controller, the datapath and the top level

package plen_pkg;

    // fixed field widths of the request and response words
    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int ELEM_W   = 32;
    localparam int RVAL_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LCNT_W   = 9;

    // defaults for the top level parameters
    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    // cells per first-level group of the removal read tree
    localparam int GROUP_SIZE = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_TAIL = 3'd1,
        ACT_INS_POS  = 3'd2,
        ACT_REM_HEAD = 3'd3,
        ACT_REM_TAIL = 3'd4,
        ACT_REM_POS  = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // what the commit cycle does to the cell array
    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_REM
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the request word
        logic look;    // register decode and removal read tree
        logic commit;  // shift cells, update count, fill output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being drained this cycle
    } t_ctrl_stat;

endpackage

>>> design/plen_in_if.sv
// plen_in_if: request channel of the positional list engine
// depends on plen_pkg for field widths

interface plen_in_if;
    logic                          valid;
    logic                          ready;
    logic [plen_pkg::ACTION_W-1:0] action;
    logic [plen_pkg::POS_W-1:0]    position;
    logic [plen_pkg::ELEM_W-1:0]   element_value;

    modport source (output valid, output action, output position, output element_value,
                    input ready);
    modport sink   (input valid, input action, input position, input element_value,
                    output ready);
endinterface

>>> design/plen_out_if.sv
// plen_out_if: response channel of the positional list engine
// depends on plen_pkg for field widths

interface plen_out_if;
    logic                          valid;
    logic                          ready;
    logic [plen_pkg::RVAL_W-1:0]   removed_value;
    logic                          removed_valid;
    logic [plen_pkg::STATUS_W-1:0] status;
    logic [plen_pkg::LCNT_W-1:0]   list_count;

    modport source (output valid, output removed_value, output removed_valid,
                    output status, output list_count, input ready);
    modport sink   (input valid, input removed_value, input removed_valid,
                    input status, input list_count, output ready);
endinterface

>>> design/positional_list_engine_unit.sv
// positional_list_engine_unit: top level of the positional list engine
// depends on plen_pkg, plen_in_if, plen_out_if, plen_ctrl and plen_dpath
//
//   channel  dir  modport  payload
//   i_req    in   sink     action, position, element_value
//   o_rsp    out  source   removed_value, removed_valid, status, list_count
//
// each accepted word passes a look state that decodes the action against the
// count and registers the first level of the removal read tree, then a commit
// state that shifts the cell array and updates the count; the next word is
// taken in the commit state as the last one commits, and also in idle
// the result sits in an output register; a full output register stalls commit
// synchronous active-low reset clears the sequencer, the count and the output
// valid; the cells are not cleared, only entries below the count are read

module positional_list_engine_unit #(
    parameter int CAPACITY   = plen_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = plen_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plen_in_if.sink    i_req,
    plen_out_if.source o_rsp
);

    // command and status between sequencer and datapath
    plen_pkg::t_ctrl_cmd  w_cmd;
    plen_pkg::t_ctrl_stat w_stat;

    // sequencer: idle, look, commit
    plen_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // cells, count, read tree and output register
    plen_dpath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_action        (i_req.action),
        .i_position      (i_req.position),
        .i_element_value (i_req.element_value),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_removed_value (o_rsp.removed_value),
        .o_removed_valid (o_rsp.removed_valid),
        .o_status        (o_rsp.status),
        .o_list_count    (o_rsp.list_count)
    );

endmodule

>>> design/plen_ctrl.sv
// plen_ctrl: sequencer for the positional list engine (idle, look, commit)
// depends on plen_pkg for the state type and the command and status structs

module plen_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  plen_pkg::t_ctrl_stat i_stat,
    output plen_pkg::t_ctrl_cmd  o_cmd
);

    plen_pkg::t_state r_state;
    plen_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plen_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plen_pkg::S_IDLE: begin
                if (i_in_valid) n_state = plen_pkg::S_LOOK;
            end
            plen_pkg::S_LOOK: begin
                n_state = plen_pkg::S_COMMIT;
            end
            plen_pkg::S_COMMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_in_valid ? plen_pkg::S_LOOK : plen_pkg::S_IDLE;
                end
            end
            default: n_state = plen_pkg::S_IDLE;
        endcase
    end

    // outputs; a new word is taken in idle and in the commit cycle
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            plen_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            plen_pkg::S_LOOK: begin
                o_cmd.look = 1'b1;
            end
            plen_pkg::S_COMMIT: begin
                o_in_ready   = i_stat.out_free;
                o_cmd.commit = i_stat.out_free;
                o_cmd.load   = i_stat.out_free && i_in_valid;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/plen_dpath.sv
// plen_dpath: shifting cell array, count, removal read tree and output register
// depends on plen_pkg for codes, widths and the command and status structs

module plen_dpath #(
    parameter int CAPACITY   = plen_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = plen_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plen_pkg::t_ctrl_cmd           i_cmd,
    output plen_pkg::t_ctrl_stat          o_stat,
    input  logic [plen_pkg::ACTION_W-1:0] i_action,
    input  logic [plen_pkg::POS_W-1:0]    i_position,
    input  logic [plen_pkg::ELEM_W-1:0]   i_element_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [plen_pkg::RVAL_W-1:0]   o_removed_value,
    output logic                          o_removed_valid,
    output logic [plen_pkg::STATUS_W-1:0] o_status,
    output logic [plen_pkg::LCNT_W-1:0]   o_list_count
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > plen_pkg::POS_W) ? CNT_W : plen_pkg::POS_W;
    localparam int NGROUP = (CAPACITY + plen_pkg::GROUP_SIZE - 1) / plen_pkg::GROUP_SIZE;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [CMP_W-1:0]      t_cmp;

    // request capture
    plen_pkg::t_action         r_action;
    logic [plen_pkg::POS_W-1:0] r_pos;
    t_value                    r_value;

    // decoded operation, held from look to commit
    plen_pkg::t_op     r_op;
    plen_pkg::t_status r_status;
    t_idx              r_target;
    t_value            r_partial [NGROUP];

    t_value r_cells [CAPACITY];
    t_value n_cells [CAPACITY];
    t_cnt   r_count;
    t_cnt   n_count;

    logic                          r_out_valid;
    logic [plen_pkg::RVAL_W-1:0]   r_out_value;
    logic                          r_out_rvalid;
    logic [plen_pkg::STATUS_W-1:0] r_out_status;
    logic [plen_pkg::LCNT_W-1:0]   r_out_count;

    plen_pkg::t_op     look_op;
    plen_pkg::t_status look_status;
    t_idx              look_target;
    t_value            look_partial [NGROUP];
    t_cmp              pos_ext;
    t_cmp              cnt_ext;
    logic              full;
    t_value            removed;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= plen_pkg::t_action'(i_action);
            r_pos    <= i_position;
            r_value  <= t_value'(i_element_value);
        end
    end

    // decode against the current count
    assign pos_ext = t_cmp'(r_pos);
    assign cnt_ext = t_cmp'(r_count);
    assign full    = (r_count == t_cnt'(CAPACITY));

    always_comb begin
        look_op     = plen_pkg::OP_NONE;
        look_status = plen_pkg::ST_DONE;
        look_target = '0;
        unique case (r_action)
            plen_pkg::ACT_INS_HEAD: begin
                if (full) look_status = plen_pkg::ST_FULL;
                else      look_op     = plen_pkg::OP_INS;
            end
            plen_pkg::ACT_INS_TAIL: begin
                if (full) look_status = plen_pkg::ST_FULL;
                else      look_op     = plen_pkg::OP_INS;
                look_target = t_idx'(r_count);
            end
            plen_pkg::ACT_INS_POS: begin
                if (full) look_status = plen_pkg::ST_FULL;
                else      look_op     = plen_pkg::OP_INS;
                // past the end appends
                look_target = t_idx'((pos_ext < cnt_ext) ? pos_ext : cnt_ext);
            end
            plen_pkg::ACT_REM_HEAD: begin
                if (r_count != '0) look_op     = plen_pkg::OP_REM;
                else               look_status = plen_pkg::ST_EMPTY;
            end
            plen_pkg::ACT_REM_TAIL: begin
                if (r_count != '0) look_op     = plen_pkg::OP_REM;
                else               look_status = plen_pkg::ST_EMPTY;
                look_target = t_idx'(r_count - t_cnt'(1));
            end
            plen_pkg::ACT_REM_POS: begin
                if (pos_ext < cnt_ext) look_op     = plen_pkg::OP_REM;
                else                   look_status = plen_pkg::ST_EMPTY;
                look_target = t_idx'(pos_ext);
            end
            default: begin
                look_op = plen_pkg::OP_NONE;
            end
        endcase
    end

    // first level of the removal read: one-hot select, or'ed per group
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            look_partial[g] = '0;
            for (int m = 0; m < plen_pkg::GROUP_SIZE; m++) begin
                if ((g * plen_pkg::GROUP_SIZE + m) < CAPACITY) begin
                    if (look_target == t_idx'(g * plen_pkg::GROUP_SIZE + m)) begin
                        look_partial[g] = look_partial[g]
                                        | r_cells[g * plen_pkg::GROUP_SIZE + m];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_op      <= look_op;
            r_status  <= look_status;
            r_target  <= look_target;
            r_partial <= look_partial;
        end
    end

    // each cell sees only its two neighbors
    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        localparam t_idx CELL_IDX = t_idx'(c);
        t_value w_left;
        t_value w_right;

        if (c == 0) begin : g_first
            assign w_left = r_cells[c];
        end else begin : g_inner_l
            assign w_left = r_cells[c-1];
        end

        if (c == CAPACITY - 1) begin : g_last
            assign w_right = r_cells[c];
        end else begin : g_inner_r
            assign w_right = r_cells[c+1];
        end

        always_comb begin
            n_cells[c] = r_cells[c];
            if (r_op == plen_pkg::OP_INS) begin
                if (CELL_IDX == r_target)     n_cells[c] = r_value;
                else if (CELL_IDX > r_target) n_cells[c] = w_left;
            end else if (r_op == plen_pkg::OP_REM) begin
                if (CELL_IDX >= r_target) n_cells[c] = w_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_cells <= n_cells;
        end
    end

    always_comb begin
        n_count = r_count;
        unique case (r_op)
            plen_pkg::OP_INS:  n_count = r_count + t_cnt'(1);
            plen_pkg::OP_REM:  n_count = r_count - t_cnt'(1);
            plen_pkg::OP_NONE: n_count = r_count;
            default:           n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // second level of the removal read
    always_comb begin
        removed = '0;
        for (int g = 0; g < NGROUP; g++) begin
            removed = removed | r_partial[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_value  <= (r_op == plen_pkg::OP_REM) ? plen_pkg::RVAL_W'(removed) : '0;
            r_out_rvalid <= (r_op == plen_pkg::OP_REM);
            r_out_status <= r_status;
            r_out_count  <= plen_pkg::LCNT_W'(n_count);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_out_value;
    assign o_removed_valid = r_out_rvalid;
    assign o_status        = r_out_status;
    assign o_list_count    = r_out_count;

endmodule

>>> tb/plen_list_checker.sv
// plen_list_checker: watches both channels of the positional list engine and
// predicts every result word; depends on plen_pkg for widths and codes

module plen_list_checker #(
    parameter int CAPACITY = plen_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic [plen_pkg::ACTION_W-1:0] i_req_action,
    input  logic [plen_pkg::POS_W-1:0]    i_req_position,
    input  logic [plen_pkg::ELEM_W-1:0]   i_req_value,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic [plen_pkg::RVAL_W-1:0]   i_rsp_removed_value,
    input  logic                          i_rsp_removed_valid,
    input  logic [plen_pkg::STATUS_W-1:0] i_rsp_status,
    input  logic [plen_pkg::LCNT_W-1:0]   i_rsp_list_count,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [plen_pkg::RVAL_W-1:0]   removed_value;
        logic                          removed_valid;
        logic [plen_pkg::STATUS_W-1:0] status;
        logic [plen_pkg::LCNT_W-1:0]   list_count;
    } t_list_result;

    logic [plen_pkg::ELEM_W-1:0] shadow_list[$];      // index 0 is the head
    t_list_result                expected_results[$];
    int                          fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    // apply one action to the shadow list and return the word it should produce
    function automatic t_list_result predict_list_action(
        input logic [plen_pkg::ACTION_W-1:0] act,
        input logic [plen_pkg::POS_W-1:0]    pos,
        input logic [plen_pkg::ELEM_W-1:0]   val
    );
        t_list_result res;
        int           held;
        int           slot;
        res  = '0;
        held = shadow_list.size();
        slot = 0;
        case (act)
            plen_pkg::ACT_INS_HEAD, plen_pkg::ACT_INS_TAIL, plen_pkg::ACT_INS_POS: begin
                if (held >= CAPACITY) begin
                    res.status = plen_pkg::ST_FULL;
                end else begin
                    if (act == plen_pkg::ACT_INS_HEAD) begin
                        slot = 0;
                    end else if (act == plen_pkg::ACT_INS_TAIL) begin
                        slot = held;
                    end else begin
                        // past the end means append
                        slot = (int'(pos) > held) ? held : int'(pos);
                    end
                    shadow_list.insert(slot, val);
                end
            end
            plen_pkg::ACT_REM_HEAD, plen_pkg::ACT_REM_TAIL, plen_pkg::ACT_REM_POS: begin
                if (act == plen_pkg::ACT_REM_HEAD) begin
                    slot = 0;
                end else if (act == plen_pkg::ACT_REM_TAIL) begin
                    slot = held - 1;
                end else begin
                    slot = int'(pos);
                end
                if (held == 0 || slot >= held) begin
                    res.status = plen_pkg::ST_EMPTY;
                end else begin
                    res.removed_value = shadow_list[slot];
                    res.removed_valid = 1'b1;
                    shadow_list.delete(slot);
                end
            end
            default: begin
                // spare codes leave the list alone
            end
        endcase
        res.list_count = plen_pkg::LCNT_W'(shadow_list.size());
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected 0x%h, actual 0x%h", field, want, got);
        end
    endtask

    // result side first: a word leaving at this edge never belongs to one entering now
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $error("result word with no request waiting, list_count 0x%h",
                           i_rsp_list_count);
                end else begin
                    want = expected_results.pop_front();
                    check_field("removed_value", 32'(want.removed_value),
                                32'(i_rsp_removed_value));
                    check_field("removed_valid", 32'(want.removed_valid),
                                32'(i_rsp_removed_valid));
                    check_field("status", 32'(want.status), 32'(i_rsp_status));
                    check_field("list_count", 32'(want.list_count), 32'(i_rsp_list_count));
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(
                    predict_list_action(i_req_action, i_req_position, i_req_value));
        end
    end

endmodule

>>> tb/tb_positional_list_engine_unit.sv
// tb_positional_list_engine_unit: stimulus and verdict for the positional list engine
// depends on plen_pkg, plen_in_if, plen_out_if, positional_list_engine_unit and plen_list_checker

module tb_positional_list_engine_unit;

    // action codes the block has no meaning for, it must ignore them
    localparam logic [plen_pkg::ACTION_W-1:0] ACT_RSVD_6 = 3'd6;
    localparam logic [plen_pkg::ACTION_W-1:0] ACT_RSVD_7 = 3'd7;

    localparam int CAPACITY = plen_pkg::CAPACITY_DEF;
    localparam int MAX_POS  = (1 << plen_pkg::POS_W) - 1;

    logic clk;
    logic rst_n;

    plen_in_if  req_if();
    plen_out_if rsp_if();

    int fail_count;
    int pending;

    // steering only: rough fill level so the random part can reach full and empty
    int steer_level = 0;
    int words_sent  = 0;
    bit quiet_tail  = 1'b0;   // no idling on either side once set

    positional_list_engine_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    plen_list_checker #(.CAPACITY(CAPACITY)) list_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_req_valid         (req_if.valid),
        .i_req_ready         (req_if.ready),
        .i_req_action        (req_if.action),
        .i_req_position      (req_if.position),
        .i_req_value         (req_if.element_value),
        .i_rsp_valid         (rsp_if.valid),
        .i_rsp_ready         (rsp_if.ready),
        .i_rsp_removed_value (rsp_if.removed_value),
        .i_rsp_removed_valid (rsp_if.removed_valid),
        .i_rsp_status        (rsp_if.status),
        .i_rsp_list_count    (rsp_if.list_count),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // 20 unit clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("tb_positional_list_engine_unit failed");
        $finish;
    end

    // offer one word, with an optional idle burst first, and hold it until taken
    task automatic send_word(input logic [plen_pkg::ACTION_W-1:0] act,
                             input logic [plen_pkg::POS_W-1:0] pos,
                             input logic [plen_pkg::ELEM_W-1:0] val);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.action        <= act;
        req_if.position      <= pos;
        req_if.element_value <= val;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        // track the fill level for steering
        if (act == plen_pkg::ACT_INS_HEAD || act == plen_pkg::ACT_INS_TAIL ||
            act == plen_pkg::ACT_INS_POS) begin
            if (steer_level < CAPACITY) steer_level++;
        end else if (act == plen_pkg::ACT_REM_HEAD || act == plen_pkg::ACT_REM_TAIL) begin
            if (steer_level > 0) steer_level--;
        end else if (act == plen_pkg::ACT_REM_POS) begin
            if (int'(pos) < steer_level) steer_level--;
        end
        words_sent++;
    endtask

    // random word; ins_pct and rsvd_pct shape the mix, the rest are removals
    task automatic send_random(input int ins_pct, input int rsvd_pct);
        logic [plen_pkg::ACTION_W-1:0] act;
        logic [plen_pkg::POS_W-1:0]    pos;
        int                            roll;
        int                            top_slot;
        roll = $urandom_range(0, 99);
        pos  = plen_pkg::POS_W'($urandom_range(0, MAX_POS));
        if (roll < rsvd_pct) begin
            act = ($urandom_range(0, 1) == 0) ? ACT_RSVD_6 : ACT_RSVD_7;
        end else if (roll < rsvd_pct + ins_pct) begin
            case ($urandom_range(0, 2))
                0:       act = plen_pkg::ACT_INS_HEAD;
                1:       act = plen_pkg::ACT_INS_TAIL;
                default: act = plen_pkg::ACT_INS_POS;
            endcase
            // mostly a slot inside the list or just at its end
            if (act == plen_pkg::ACT_INS_POS && $urandom_range(0, 3) != 0) begin
                top_slot = (steer_level > MAX_POS) ? MAX_POS : steer_level;
                pos = plen_pkg::POS_W'($urandom_range(0, top_slot));
            end
        end else begin
            case ($urandom_range(0, 2))
                0:       act = plen_pkg::ACT_REM_HEAD;
                1:       act = plen_pkg::ACT_REM_TAIL;
                default: act = plen_pkg::ACT_REM_POS;
            endcase
            // mostly a position that holds an element
            if (act == plen_pkg::ACT_REM_POS && steer_level > 0 &&
                $urandom_range(0, 4) != 0)
                pos = plen_pkg::POS_W'($urandom_range(0, steer_level - 1));
        end
        send_word(act, pos, $urandom);
    endtask

    // result side: random stall bursts, plus one long hold-off so the block
    // fills up and pushes back on the request channel
    initial begin
        int  stall;
        bit  hold_done;
        hold_done = 1'b0;
        rsp_if.ready = 1'b1;
        forever begin
            @(posedge clk);
            if (!hold_done && words_sent >= 60) begin
                hold_done = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (300) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 13);
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.action        = plen_pkg::ACT_INS_HEAD;
        req_if.position      = '0;
        req_if.element_value = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: removals from the empty list
        send_word(plen_pkg::ACT_REM_HEAD, 8'd0, 32'h0);
        send_word(plen_pkg::ACT_REM_TAIL, 8'd0, 32'h0);
        send_word(plen_pkg::ACT_REM_POS, 8'd0, 32'hFFFF_FFFF);
        // insert past the end appends, then build a short list
        send_word(plen_pkg::ACT_INS_POS, 8'd255, 32'hFFFF_FFFF);
        send_word(plen_pkg::ACT_INS_HEAD, 8'd0, 32'h0000_0000);
        send_word(plen_pkg::ACT_INS_TAIL, 8'd17, 32'hA5A5_5A5A);
        send_word(plen_pkg::ACT_INS_POS, 8'd1, 32'h1234_5678);
        send_word(plen_pkg::ACT_INS_POS, 8'd0, 32'hFFFF_0000);
        // position equal to the count lands at the tail
        send_word(plen_pkg::ACT_INS_POS, 8'd5, 32'h0000_FFFF);
        // spare codes do nothing
        send_word(ACT_RSVD_6, 8'd3, 32'hDEAD_BEEF);
        send_word(ACT_RSVD_7, 8'd255, 32'hFFFF_FFFF);
        // remove past the end and exactly at the end: nothing to take
        send_word(plen_pkg::ACT_REM_POS, 8'd255, 32'h0);
        send_word(plen_pkg::ACT_REM_POS, 8'd6, 32'h0);
        // take everything back out through every kind of removal
        send_word(plen_pkg::ACT_REM_POS, 8'd2, 32'h0);
        send_word(plen_pkg::ACT_REM_POS, 8'd0, 32'h0);
        send_word(plen_pkg::ACT_REM_TAIL, 8'd0, 32'h0);
        send_word(plen_pkg::ACT_REM_HEAD, 8'd0, 32'h0);
        send_word(plen_pkg::ACT_REM_POS, 8'd1, 32'h0);
        send_word(plen_pkg::ACT_REM_TAIL, 8'd0, 32'h0);
        send_word(plen_pkg::ACT_REM_TAIL, 8'd200, 32'h0);

        // random: balanced warm-up, the long hold-off lands in here
        repeat (100) send_random(48, 4);
        // fill to capacity, then linger at full so inserts get refused
        while (steer_level < CAPACITY) send_random(90, 2);
        repeat (30) send_random(85, 2);
        // drain to empty and linger there
        while (steer_level > 0) send_random(10, 2);
        repeat (20) send_random(10, 2);
        // balanced again, the last stretch with no idling at all
        repeat (100) send_random(48, 4);
        quiet_tail = 1'b1;
        repeat (80) send_random(48, 4);
        req_if.valid <= 1'b0;

        // let every result drain, then keep watching for stray words
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_positional_list_engine_unit passed");
        end else begin
            $display("tb_positional_list_engine_unit failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/plen_pkg.sv
design/plen_in_if.sv
design/plen_out_if.sv
design/plen_ctrl.sv
design/plen_dpath.sv
design/positional_list_engine_unit.sv
tb/plen_list_checker.sv
tb/tb_positional_list_engine_unit.sv
